>>> rtl/vector_angle_degrees_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vector angle block
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_DEGREES_MACROS_SVH
`define VECTOR_ANGLE_DEGREES_MACROS_SVH

`ifndef SYNTHESIS
// Check on every rising edge of clk_i outside reset.
`define VAD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vector_angle_degrees: assertion failed");
// Check on every rising edge of clk_i, reset included.
`define VAD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("vector_angle_degrees: assertion failed");
`else
`define VAD_ASSERT(lbl, prop)
`define VAD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/vad_pkg.sv
// ----------------------------------------------------------------------------
// vad_pkg
// Widths, constants and stage word types of the vector angle pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vad_pkg;

  localparam int unsigned CoordWidth = 16;          // signed input width
  localparam int unsigned MagWidth   = CoordWidth;  // |v| up to 2^(W-1)
  localparam int unsigned QuoWidth   = 6;           // quotient 0..45
  localparam int unsigned RemWidth   = CoordWidth + QuoWidth;
  localparam int unsigned DshWidth   = CoordWidth + QuoWidth - 1;
  localparam int unsigned AngWidth   = 9;
  localparam int unsigned MirWidth   = 7;
  localparam int unsigned CorrWidth  = 3;

  localparam logic [AngWidth-1:0] AngRight = 9'd90;
  localparam logic [AngWidth-1:0] AngHalf  = 9'd180;
  localparam logic [AngWidth-1:0] AngFull  = 9'd360;

  // Correction thresholds for the upper and lower halves of the octant.
  localparam logic [QuoWidth-1:0] QuoSplit = 6'd22;
  localparam logic [QuoWidth-1:0] HiTh0    = 6'd44;
  localparam logic [QuoWidth-1:0] HiTh1    = 6'd41;
  localparam logic [QuoWidth-1:0] HiTh2    = 6'd37;
  localparam logic [QuoWidth-1:0] HiTh3    = 6'd32;
  localparam logic [QuoWidth-1:0] LoTh0    = 6'd2;
  localparam logic [QuoWidth-1:0] LoTh1    = 6'd6;
  localparam logic [QuoWidth-1:0] LoTh2    = 6'd10;
  localparam logic [QuoWidth-1:0] LoTh3    = 6'd15;

  typedef struct packed {
    logic                  x_neg;
    logic                  y_neg;
    logic                  zero;
    logic                  wide_x;
    logic [MagWidth-1:0]   num;
    logic [MagWidth-1:0]   den;
  } vad_mag_t;

  typedef struct packed {
    logic                  x_neg;
    logic                  y_neg;
    logic                  zero;
    logic                  wide_x;
    logic [RemWidth-1:0]   rem;
    logic [DshWidth-1:0]   dsh;
    logic [QuoWidth-1:0]   quo;
  } vad_div_t;

endpackage

>>> rtl/vad_if.sv
// ----------------------------------------------------------------------------
// vad_if
// Valid/ready channels carrying vector words in and angle words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vad_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vad_pkg::CoordWidth-1:0] x_coord;
  logic signed [vad_pkg::CoordWidth-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vad_out_if;
  logic                          valid;
  logic                          ready;
  logic [vad_pkg::AngWidth-1:0]  angle_degrees;
  logic                          zero_vector;

  modport source (output valid, output angle_degrees, output zero_vector, input ready);
  modport sink   (input valid, input angle_degrees, input zero_vector, output ready);
endinterface

>>> rtl/vad_front.sv
// ----------------------------------------------------------------------------
// vad_front
// Magnitudes, octant compare, then min*45 and the aligned divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vad_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  vad_in_if.sink            vec_i,
  output logic              out_valid_o,
  output vad_pkg::vad_div_t out_pkt_o,
  input  logic              out_ready_i
);
  import vad_pkg::*;

  logic                  x_neg, y_neg;
  logic [MagWidth-1:0]   x_mag, y_mag;
  vad_mag_t              mag_d, mag_q;
  logic                  mag_v_q, mag_rdy;
  vad_div_t              div_d, div_q;
  logic                  div_v_q, div_rdy;
  logic [RemWidth-1:0]   num_w;

  // Stage A: magnitudes and the smaller/larger pick.
  always_comb begin
    x_neg = vec_i.x_coord[CoordWidth-1];
    y_neg = vec_i.y_coord[CoordWidth-1];
    x_mag = x_neg ? MagWidth'(~vec_i.x_coord + 1'b1) : MagWidth'(vec_i.x_coord);
    y_mag = y_neg ? MagWidth'(~vec_i.y_coord + 1'b1) : MagWidth'(vec_i.y_coord);
    mag_d.x_neg  = x_neg;
    mag_d.y_neg  = y_neg;
    mag_d.zero   = (x_mag == '0) && (y_mag == '0);
    mag_d.wide_x = x_mag > y_mag;
    mag_d.num    = mag_d.wide_x ? y_mag : x_mag;
    mag_d.den    = mag_d.wide_x ? x_mag : y_mag;
  end

  assign div_rdy     = !div_v_q || out_ready_i;
  assign mag_rdy     = !mag_v_q || div_rdy;
  assign vec_i.ready = mag_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_v_q <= 1'b0;
    end else if (mag_rdy) begin
      mag_v_q <= vec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_rdy && vec_i.valid) begin
      mag_q <= mag_d;
    end
  end

  // Stage B: scale the smaller magnitude by 45 as shifts and adds.
  always_comb begin
    num_w        = RemWidth'(mag_q.num);
    div_d.x_neg  = mag_q.x_neg;
    div_d.y_neg  = mag_q.y_neg;
    div_d.zero   = mag_q.zero;
    div_d.wide_x = mag_q.wide_x;
    div_d.rem    = (num_w << 5) + (num_w << 3) + (num_w << 2) + num_w;
    div_d.dsh    = {mag_q.den, {(QuoWidth-1){1'b0}}};
    div_d.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q <= 1'b0;
    end else if (div_rdy) begin
      div_v_q <= mag_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_rdy && mag_v_q) begin
      div_q <= div_d;
    end
  end

  assign out_valid_o = div_v_q;
  assign out_pkt_o   = div_q;

endmodule

>>> rtl/vad_div_step.sv
// ----------------------------------------------------------------------------
// vad_div_step
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vad_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  vad_pkg::vad_div_t in_pkt_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output vad_pkg::vad_div_t out_pkt_o,
  input  logic              out_ready_i
);
  import vad_pkg::*;

  vad_div_t            pkt_d, pkt_q;
  logic                v_q;
  logic                fits;
  logic [RemWidth-1:0] dsh_w;

  always_comb begin
    dsh_w       = RemWidth'(in_pkt_i.dsh);
    fits        = in_pkt_i.rem >= dsh_w;
    pkt_d       = in_pkt_i;
    pkt_d.rem   = fits ? in_pkt_i.rem - dsh_w : in_pkt_i.rem;
    pkt_d.dsh   = in_pkt_i.dsh >> 1;
    pkt_d.quo   = {in_pkt_i.quo[QuoWidth-2:0], fits};
  end

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_pkt_o   = pkt_q;

endmodule

>>> rtl/vad_back.sv
// ----------------------------------------------------------------------------
// vad_back
// Curve correction, octant mirror, quadrant fold and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vad_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  vad_pkg::vad_div_t in_pkt_i,
  output logic              in_ready_o,
  vad_out_if.source         ang_o
);
  import vad_pkg::*;

  logic [QuoWidth-1:0]  q;
  logic [CorrWidth-1:0] corr;
  logic [QuoWidth-1:0]  fixed;
  logic [MirWidth-1:0]  mir;
  logic [AngWidth-1:0]  mir_w;
  logic [AngWidth-1:0]  ang_d, ang_q;
  logic                 zero_q;
  logic                 v_q;

  always_comb begin
    q = in_pkt_i.quo;
    if (q > QuoSplit) begin
      corr = CorrWidth'(q <= HiTh0) + CorrWidth'(q <= HiTh1)
           + CorrWidth'(q <= HiTh2) + CorrWidth'(q <= HiTh3);
    end else begin
      corr = CorrWidth'(q >= LoTh0) + CorrWidth'(q >= LoTh1)
           + CorrWidth'(q >= LoTh2) + CorrWidth'(q >= LoTh3);
    end
    fixed = q + QuoWidth'(corr);
    mir   = in_pkt_i.wide_x ? MirWidth'(AngRight) - MirWidth'(fixed) : MirWidth'(fixed);
    mir_w = AngWidth'(mir);
    if (in_pkt_i.zero) begin
      ang_d = '0;
    end else if (in_pkt_i.y_neg && in_pkt_i.x_neg) begin
      ang_d = AngHalf + mir_w;
    end else if (in_pkt_i.y_neg) begin
      ang_d = AngHalf - mir_w;
    end else if (in_pkt_i.x_neg) begin
      ang_d = AngFull - mir_w;
    end else begin
      ang_d = mir_w;
    end
  end

  assign in_ready_o = !v_q || ang_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ang_q  <= ang_d;
      zero_q <= in_pkt_i.zero;
    end
  end

  assign ang_o.valid         = v_q;
  assign ang_o.angle_degrees = ang_q;
  assign ang_o.zero_vector   = zero_q;

endmodule

>>> rtl/vector_angle_degrees.sv
// ----------------------------------------------------------------------------
// vector_angle_degrees
// Pipelined integer atan2 in degrees, measured from +Y toward +X.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                          handshake
//   vec_i     in    x_coord, y_coord (signed 16)     valid/ready
//   ang_o     out   angle_degrees (9), zero_vector   valid/ready
//
// Flow: one word in per cycle unless ang_o stalls; a taken word passes
//   2 front stages, 6 divider stages of one quotient bit each and 1 output.
// Most stages belong to the divider; every stage holds one word.
// Reset clears all stage valid bits asynchronously; payload is not reset.
// Stalls: ready ripples back from ang_o through each stage; a stage takes
//   a new word whenever it is empty or its own word moves on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "vector_angle_degrees_macros.svh"

module vector_angle_degrees (
  input  logic      clk_i,
  input  logic      rst_ni,
  vad_in_if.sink    vec_i,
  vad_out_if.source ang_o
);
  import vad_pkg::*;

  // Stage boundaries: index 0 leaves the front end, QuoWidth enters the back.
  vad_div_t div_pkt [QuoWidth+1];
  logic     div_v   [QuoWidth+1];
  logic     div_rdy [QuoWidth+1];

  // Take magnitudes and scale the smaller one by 45.
  vad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vec_i       (vec_i),
    .out_valid_o (div_v[0]),
    .out_pkt_o   (div_pkt[0]),
    .out_ready_i (div_rdy[0])
  );

  // Develop the quotient one bit per stage, MSB first.
  for (genvar i = 0; i < QuoWidth; i++) begin : g_div
    vad_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_v[i]),
      .in_pkt_i    (div_pkt[i]),
      .in_ready_o  (div_rdy[i]),
      .out_valid_o (div_v[i+1]),
      .out_pkt_o   (div_pkt[i+1]),
      .out_ready_i (div_rdy[i+1])
    );
  end

  // Correct, mirror, fold into the quadrant and hold the result word.
  vad_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_v[QuoWidth]),
    .in_pkt_i   (div_pkt[QuoWidth]),
    .in_ready_o (div_rdy[QuoWidth]),
    .ang_o      (ang_o)
  );

  // A word moved out of the last divider stage shows up on the output.
  `VAD_ASSERT(a_last_to_out, div_v[QuoWidth] && div_rdy[QuoWidth] |=> ang_o.valid)
  // A stalled front word stays in place.
  `VAD_ASSERT(a_front_hold, div_v[0] && !div_rdy[0] |=> div_v[0])
  // A zero vector always reports angle 0, and no angle exceeds a full turn.
  `VAD_ASSERT(a_zero_angle, ang_o.valid && ang_o.zero_vector |-> ang_o.angle_degrees == '0)
  `VAD_ASSERT(a_angle_range, ang_o.valid |-> ang_o.angle_degrees <= AngFull)
  // No word is shown while reset is held.
  `VAD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !ang_o.valid)

endmodule

>>> verif/tb_vector_angle_degrees.sv
// ----------------------------------------------------------------------------
// tb_vector_angle_degrees
// Self-checking bench for the pipelined integer atan2 in degrees.
//   A table of directed vectors covers the axes, the most negative inputs,
//   the zero vector, the full turn to 360 and each correction threshold
//   but 6 and 10. Then four random phases run with and without sender idling
//   and receiver stalls. Words are checked on typed angles or a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vector_angle_degrees;
  import vad_pkg::*;

  // Run limits.
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 20;    // pipeline is 9 deep
  localparam int unsigned WordsPerPhase = 190;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned NumRows       = 25;
  localparam int unsigned OctantDeg     = 45;    // full scale of the quotient
  localparam int unsigned MaxMult       = 720;   // 45 * 720 stays below 2^15

  typedef logic signed [CoordWidth-1:0] coord_t;

  // One angle word as the output channel carries it.
  typedef struct packed {
    logic [AngWidth-1:0] angle;
    logic                zero;
  } angle_word_t;

  // One directed vector; the angle is typed in only where typed is set.
  typedef struct packed {
    int x;
    int y;
    bit typed;
    int angle;
    bit zero;
  } vector_row_t;

  logic clk_i;
  logic rst_ni;

  vad_in_if  vec_if ();
  vad_out_if ang_if ();

  vector_angle_degrees u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vec_i  (vec_if),
    .ang_o  (ang_if)
  );

  // Angle words still owed by the block, oldest first.
  angle_word_t angle_q[$];
  angle_word_t head_word;

  int          idle_pct;
  int          stall_pct;
  int unsigned cycle_count;
  int unsigned error_count    = 0;
  int unsigned words_sent;
  int unsigned results_seen   = 0;
  int unsigned zero_seen      = 0;
  int unsigned full_turn_seen = 0;

  // Phases: no idling, sender idle, receiver stalling, both.
  int phase_idle  [NumPhases] = '{0, 87, 0, 22};
  int phase_stall [NumPhases] = '{0, 0, 87, 22};

  // Directed vectors: axes, extremes, zero vector, full turn, thresholds.
  vector_row_t dir_rows [NumRows] = '{
    '{0,      0,      1'b1, 0,   1'b1},  // zero vector: angle 0, flag set
    '{0,      100,    1'b1, 0,   1'b0},  // +Y axis
    '{100,    0,      1'b1, 90,  1'b0},  // +X axis
    '{0,      -100,   1'b1, 180, 1'b0},  // -Y axis, zero X counts positive
    '{-100,   0,      1'b1, 270, 1'b0},  // -X axis
    '{-32768, 0,      1'b1, 270, 1'b0},  // most negative X
    '{0,      -32768, 1'b1, 180, 1'b0},  // most negative Y
    '{32767,  0,      1'b1, 90,  1'b0},
    '{-32768, -32768, 1'b1, 225, 1'b0},  // diagonal, both magnitudes 2^15
    '{32767,  32767,  1'b1, 45,  1'b0},
    '{-1,     100,    1'b1, 360, 1'b0},  // full turn: X negative, reported as 360
    '{-1,     32767,  1'b1, 360, 1'b0},
    '{-32768, 32767,  1'b0, 0,   1'b0},
    '{32767,  -32768, 1'b0, 0,   1'b0},
    '{-32768, -1,     1'b0, 0,   1'b0},
    '{1,      -32768, 1'b1, 180, 1'b0},
    '{1,      45,     1'b0, 0,   1'b0},  // quotient 1: no correction
    '{-2,     45,     1'b0, 0,   1'b0},  // first lower step
    '{15,     -45,    1'b0, 0,   1'b0},  // last lower step
    '{-22,    -45,    1'b0, 0,   1'b0},  // top of the lower half
    '{23,     45,     1'b0, 0,   1'b0},  // bottom of the upper half
    '{45,     32,     1'b0, 0,   1'b0},  // mirrored, upper steps
    '{-45,    37,     1'b0, 0,   1'b0},
    '{44,     -45,    1'b0, 0,   1'b0},  // last upper step
    '{45,     -41,    1'b0, 0,   1'b0}
  };

  // --------------------------------------------------------------------------
  // Angle model: magnitudes, truncated quotient times 45, stepped correction,
  // mirror past the diagonal, then fold into the quadrant of the vector.
  // --------------------------------------------------------------------------
  function automatic angle_word_t predict_angle(coord_t x, coord_t y);
    int          sx;
    int          sy;
    int unsigned ax;
    int unsigned ay;
    int unsigned lo;
    int unsigned hi;
    int unsigned quo;
    int unsigned ang;
    angle_word_t w;
    sx = x;
    sy = y;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    w.zero  = (ax == 0) && (ay == 0);
    w.angle = '0;
    if (w.zero) begin
      return w;
    end
    if (ax > ay) begin
      lo = ay;
      hi = ax;
    end else begin
      lo = ax;
      hi = ay;
    end
    quo = (lo * OctantDeg) / hi;
    ang = quo;
    // Upper half counts thresholds from above, lower half from below.
    if (quo > QuoSplit) begin
      if (quo <= HiTh0) ang++;
      if (quo <= HiTh1) ang++;
      if (quo <= HiTh2) ang++;
      if (quo <= HiTh3) ang++;
    end else begin
      if (quo >= LoTh0) ang++;
      if (quo >= LoTh1) ang++;
      if (quo >= LoTh2) ang++;
      if (quo >= LoTh3) ang++;
    end
    if (ax > ay) begin
      ang = AngRight - ang;
    end
    if (sy < 0) begin
      ang = (sx < 0) ? AngHalf + ang : AngHalf - ang;
    end else if (sx < 0) begin
      ang = AngFull - ang;
    end
    w.angle = ang[AngWidth-1:0];
    return w;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("  mismatch at cycle %0d: %s, got %0d, expected %0d",
             cycle_count, what, got, want);
  endtask

  // Offer one vector word; idle first as the phase asks, hold until taken.
  task automatic send_vector(coord_t x, coord_t y, angle_word_t want);
    while ($urandom_range(99) < idle_pct) begin
      vec_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    vec_if.valid   <= 1'b1;
    vec_if.x_coord <= x;
    vec_if.y_coord <= y;
    do @(posedge clk_i); while (!vec_if.ready);
    angle_q.push_back(want);
    words_sent++;
  endtask

  // Drop valid and hold off until every owed angle word has come back.
  task automatic wait_drained();
    vec_if.valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
  endtask

  // Free-running clock, 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: end the run as a failure once the cycle budget is spent.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("  timeout with %0d angle words still owed", angle_q.size());
    $display("[vector_angle_degrees] ERROR");
    $finish;
  end

  // Receiver: stall at random with the rate of the current phase.
  always @(posedge clk_i) begin
    ang_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Checker: compare each taken angle word with the oldest one owed.
  // Values read here are the ones from before this edge.
  always @(posedge clk_i) begin
    if (rst_ni && ang_if.valid && ang_if.ready) begin
      if (angle_q.size() == 0) begin
        report_mismatch("angle word with none owed", ang_if.angle_degrees, -1);
      end else begin
        head_word = angle_q.pop_front();
        results_seen++;
        if (ang_if.angle_degrees !== head_word.angle) begin
          report_mismatch("angle_degrees", ang_if.angle_degrees, head_word.angle);
        end
        if (ang_if.zero_vector !== head_word.zero) begin
          report_mismatch("zero_vector", ang_if.zero_vector, head_word.zero);
        end
        if (head_word.zero) zero_seen++;
        if (head_word.angle == AngFull) full_turn_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random phases.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned mx;
    int unsigned my;
    int unsigned quo;
    int unsigned mult;
    int unsigned swap;
    int          xi;
    int          yi;
    coord_t      x;
    coord_t      y;
    angle_word_t want;

    // Drive reset and the vector channel to known values from time zero.
    rst_ni         <= 1'b0;
    vec_if.valid   <= 1'b0;
    vec_if.x_coord <= '0;
    vec_if.y_coord <= '0;
    idle_pct       = 0;
    stall_pct      = 0;
    words_sent     = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: typed rows carry their own angle, the rest use the model.
    foreach (dir_rows[i]) begin
      x = dir_rows[i].x[CoordWidth-1:0];
      y = dir_rows[i].y[CoordWidth-1:0];
      if (dir_rows[i].typed) begin
        want.angle = dir_rows[i].angle[AngWidth-1:0];
        want.zero  = dir_rows[i].zero;
      end else begin
        want = predict_angle(x, y);
      end
      send_vector(x, y, want);
    end
    // Hold the sender until the pipeline has emptied once.
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (WordsPerPhase) begin
        mode = $urandom_range(9);
        if (mode == 0) begin
          // Raw words: every bit of both fields toggles.
          x = coord_t'($urandom);
          y = coord_t'($urandom);
        end else begin
          // Build magnitudes first, then apply random signs.
          case (mode)
            1: begin
              mx = $urandom_range(8);
              my = $urandom_range(8);
            end
            2: begin
              // Near the diagonal, where mirroring flips.
              mx = $urandom_range(32768);
              my = mx + $urandom_range(6);
              my = (my >= 3) ? my - 3 : 0;
              if (my > 32768) my = 32768;
            end
            3: begin
              // On or next to an axis.
              mx = $urandom_range(1);
              my = $urandom_range(32768);
            end
            4: begin
              mx = ($urandom_range(1) != 0) ? 32768 : 32767 * $urandom_range(1);
              my = ($urandom_range(1) != 0) ? 32768 : $urandom_range(1) + 32766;
            end
            default: begin
              // Steer the quotient to a chosen value with random scale,
              // so every correction step is hit often.
              quo  = $urandom_range(OctantDeg);
              mult = $urandom_range(MaxMult, 1);
              mx   = quo * mult + $urandom_range(mult - 1);
              my   = OctantDeg * mult;
            end
          endcase
          swap = $urandom_range(1);
          if (swap != 0) begin
            {mx, my} = {my, mx};
          end
          xi = ($urandom_range(1) != 0) ? -int'(mx) : int'(mx);
          yi = ($urandom_range(1) != 0) ? -int'(my) : int'(my);
          x  = xi[CoordWidth-1:0];
          y  = yi[CoordWidth-1:0];
        end
        send_vector(x, y, predict_angle(x, y));
      end
      wait_drained();
    end

    // Let the pipeline settle, then give the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    $display("  %0d vector words sent over directed rows and %0d idle/stall phases",
             words_sent, NumPhases);
    $display("  %0d angle words checked (%0d zero vectors, %0d full turns), %0d mismatches",
             results_seen, zero_seen, full_turn_seen, error_count);
    if (error_count == 0) begin
      $display("[vector_angle_degrees] OK");
    end else begin
      $display("[vector_angle_degrees] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/vad_pkg.sv
rtl/vad_if.sv
rtl/vad_front.sv
rtl/vad_div_step.sv
rtl/vad_back.sv
rtl/vector_angle_degrees.sv
verif/tb_vector_angle_degrees.sv
